FILE: sv/ps2mt_pkg.sv
package ps2mt_pkg;

  localparam int CoordBitsDefault = 12;
  localparam int CursorResetX = 512;
  localparam int CursorResetY = 384;
  localparam logic [9:0] IdleTicksMax = 10'd1023;

  localparam logic [7:0] SyncBit = 8'h08;
  localparam logic [7:0] OverflowBits = 8'hC0;

  typedef enum logic [2:0] {
    OP_BYTE = 3'd0,
    OP_TICK = 3'd1,
    OP_POLL = 3'd2,
    OP_REL  = 3'd3,
    OP_ABS  = 3'd4,
    OP_SET  = 3'd5
  } op_t;

  localparam logic [1:0] CFG_MAX_X = 2'd0;
  localparam logic [1:0] CFG_MAX_Y = 2'd1;
  localparam logic [1:0] CFG_WHEEL_MODE = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [11:0] max_x;
    logic [11:0] max_y;
    logic        wheel_mode;
    logic [9:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         data_byte;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [7:0]  scroll_step;
    logic [2:0]         button_bits;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] first;
    logic [7:0] dx_byte;
    logic [7:0] dy_byte;
    logic       wheel_en;
    logic [7:0] wheel_byte;
  } pkt_t;

  typedef struct packed {
    logic [11:0]        pointer_x;
    logic [11:0]        pointer_y;
    logic signed [31:0] sum_dx;
    logic signed [31:0] sum_dy;
    logic signed [7:0]  sum_scroll;
    logic [2:0]         buttons;
    logic               changed;
  } stat_t;

endpackage

FILE: sv/ps2mt_framer.sv
module ps2mt_framer (
  input  logic                clk,
  input  logic                rst,
  input  ps2mt_pkg::cfg_t     cfg,
  input  ps2mt_pkg::item_t    item,
  input  logic                proc,
  output ps2mt_pkg::pkt_t     pkt,
  output logic [31:0]         resync_total
);
  import ps2mt_pkg::*;

  logic [7:0] held_bytes [3];
  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [9:0] idle_ticks;
  logic [9:0] idle_ticks_next;
  logic [31:0] resync_total_next;

  logic       is_byte;
  logic       is_tick;
  logic       timed_out;
  logic [1:0] pos0;
  logic       bad_first;
  logic       complete;
  logic [7:0] b;

  always_comb begin
    b = item.data_byte;
    is_byte = proc && (item.operation == OP_BYTE);
    is_tick = proc && (item.operation == OP_TICK);
    timed_out = (byte_position != 2'd0) && (idle_ticks > cfg.timeout_ticks);
    pos0 = timed_out ? 2'd0 : byte_position;
    bad_first = (pos0 == 2'd0) && ((b & SyncBit) == 8'h00);
    complete = !bad_first && (pos0 >= (cfg.wheel_mode ? 2'd3 : 2'd2));

    pkt.first = held_bytes[0];
    pkt.dx_byte = held_bytes[1];
    pkt.dy_byte = (pos0 == 2'd2) ? b : held_bytes[2];
    pkt.wheel_en = cfg.wheel_mode && (pos0 == 2'd3);
    pkt.wheel_byte = b;
    pkt.valid = is_byte && complete && ((held_bytes[0] & SyncBit) != 8'h00)
                && ((held_bytes[0] & OverflowBits) == 8'h00);

    byte_position_next = byte_position;
    idle_ticks_next = idle_ticks;
    resync_total_next = resync_total;
    if (is_byte) begin
      idle_ticks_next = '0;
      resync_total_next = resync_total + 32'(timed_out) + 32'(bad_first);
      if (bad_first || complete) begin
        byte_position_next = 2'd0;
      end else begin
        byte_position_next = pos0 + 2'd1;
      end
    end else if (is_tick && (idle_ticks != IdleTicksMax)) begin
      idle_ticks_next = idle_ticks + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      idle_ticks <= '0;
      resync_total <= '0;
    end else begin
      byte_position <= byte_position_next;
      idle_ticks <= idle_ticks_next;
      resync_total <= resync_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (is_byte && !bad_first && (pos0 != 2'd3)) begin
      held_bytes[pos0] <= b;
    end
  end

endmodule

FILE: sv/ps2mt_tracker.sv
module ps2mt_tracker #(
  parameter int COORD_BITS = ps2mt_pkg::CoordBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  ps2mt_pkg::cfg_t     cfg,
  input  ps2mt_pkg::item_t    item,
  input  logic                proc,
  input  ps2mt_pkg::pkt_t     pkt,
  output ps2mt_pkg::stat_t    stat
);
  import ps2mt_pkg::*;

  localparam logic [COORD_BITS-1:0] CoordMax = '1;
  localparam logic [COORD_BITS-1:0] ResetX =
    (CursorResetX < (2**COORD_BITS - 1)) ? COORD_BITS'(CursorResetX) : CoordMax;
  localparam logic [COORD_BITS-1:0] ResetY =
    (CursorResetY < (2**COORD_BITS - 1)) ? COORD_BITS'(CursorResetY) : CoordMax;

  logic [COORD_BITS-1:0] cursor_x, cursor_x_next;
  logic [COORD_BITS-1:0] cursor_y, cursor_y_next;
  logic [31:0] delta_x_total, delta_x_total_next;
  logic [31:0] delta_y_total, delta_y_total_next;
  logic [7:0]  wheel_total, wheel_total_next;
  logic [2:0]  button_state, button_state_next;
  logic        update_flag, update_flag_next;

  logic [COORD_BITS-1:0] top_x, top_y;
  logic signed [15:0] rel_dx, rel_dy;
  logic signed [9:0]  pkt_dx, pkt_dy;
  logic signed [17:0] sum_x, sum_y;
  logic [COORD_BITS-1:0] rel_x, rel_y, abs_x, abs_y;
  logic [7:0] wheel_nib;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [17:0] v,
                                                  input logic [COORD_BITS-1:0] top);
    logic signed [17:0] t;
    t = $signed(18'(top));
    if (v < 18'sd0) begin
      return '0;
    end else if (v > t) begin
      return top;
    end
    return v[COORD_BITS-1:0];
  endfunction

  always_comb begin
    top_x = (17'(cfg.max_x) > 17'(CoordMax)) ? CoordMax : COORD_BITS'(cfg.max_x);
    top_y = (17'(cfg.max_y) > 17'(CoordMax)) ? CoordMax : COORD_BITS'(cfg.max_y);

    pkt_dx = $signed({pkt.first[4], pkt.first[4], pkt.dx_byte});
    pkt_dy = -$signed({pkt.first[5], pkt.first[5], pkt.dy_byte});
    if (pkt.valid) begin
      rel_dx = {{6{pkt_dx[9]}}, pkt_dx};
      rel_dy = {{6{pkt_dy[9]}}, pkt_dy};
    end else begin
      rel_dx = item.value_x;
      rel_dy = item.value_y;
    end
    sum_x = $signed(18'(cursor_x)) + {{2{rel_dx[15]}}, rel_dx};
    sum_y = $signed(18'(cursor_y)) + {{2{rel_dy[15]}}, rel_dy};
    rel_x = clamp(sum_x, top_x);
    rel_y = clamp(sum_y, top_y);
    abs_x = clamp({{2{item.value_x[15]}}, item.value_x}, top_x);
    abs_y = clamp({{2{item.value_y[15]}}, item.value_y}, top_y);
    wheel_nib = {{4{pkt.wheel_byte[3]}}, pkt.wheel_byte[3:0]};

    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    delta_x_total_next = delta_x_total;
    delta_y_total_next = delta_y_total;
    wheel_total_next = wheel_total;
    button_state_next = button_state;
    update_flag_next = update_flag;

    if (pkt.valid) begin
      cursor_x_next = rel_x;
      cursor_y_next = rel_y;
      delta_x_total_next = delta_x_total + {{16{rel_dx[15]}}, rel_dx};
      delta_y_total_next = delta_y_total + {{16{rel_dy[15]}}, rel_dy};
      if (pkt.wheel_en) begin
        wheel_total_next = wheel_total + wheel_nib;
      end
      button_state_next = pkt.first[2:0];
      update_flag_next = 1'b1;
    end else if (proc) begin
      case (op_t'(item.operation))
        OP_POLL: begin
          delta_x_total_next = '0;
          delta_y_total_next = '0;
          wheel_total_next = '0;
          update_flag_next = 1'b0;
        end
        OP_REL: begin
          cursor_x_next = rel_x;
          cursor_y_next = rel_y;
          delta_x_total_next = delta_x_total + {{16{rel_dx[15]}}, rel_dx};
          delta_y_total_next = delta_y_total + {{16{rel_dy[15]}}, rel_dy};
          wheel_total_next = wheel_total + item.scroll_step;
          button_state_next = item.button_bits;
          update_flag_next = 1'b1;
        end
        OP_ABS: begin
          cursor_x_next = abs_x;
          cursor_y_next = abs_y;
          delta_x_total_next = delta_x_total + 32'(abs_x) - 32'(cursor_x);
          delta_y_total_next = delta_y_total + 32'(abs_y) - 32'(cursor_y);
          wheel_total_next = wheel_total + item.scroll_step;
          button_state_next = item.button_bits;
          update_flag_next = 1'b1;
        end
        OP_SET: begin
          cursor_x_next = abs_x;
          cursor_y_next = abs_y;
          update_flag_next = 1'b1;
        end
        default: begin
        end
      endcase
    end

    stat.pointer_x = 12'(cursor_x);
    stat.pointer_y = 12'(cursor_y);
    stat.sum_dx = $signed(delta_x_total);
    stat.sum_dy = $signed(delta_y_total);
    stat.sum_scroll = $signed(wheel_total);
    stat.buttons = button_state;
    stat.changed = update_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= ResetX;
      cursor_y <= ResetY;
      delta_x_total <= '0;
      delta_y_total <= '0;
      wheel_total <= '0;
      button_state <= '0;
      update_flag <= 1'b0;
    end else begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      delta_x_total <= delta_x_total_next;
      delta_y_total <= delta_y_total_next;
      wheel_total <= wheel_total_next;
      button_state <= button_state_next;
      update_flag <= update_flag_next;
    end
  end

endmodule

FILE: sv/ps2_mouse_packet_tracker.sv
// A poll word is held in the input register, and its result is then stored in the result register.
// Throughput: one word per cycle; the input register and the result register
// are split so a waiting poll result only holds back the next poll.
// Reset (rst, synchronous): config to defaults, framer idle, cursor centered,
// accumulators and counters zero. Held packet bytes are not cleared.
module ps2_mouse_packet_tracker #(
  parameter int COORD_BITS = ps2mt_pkg::CoordBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic [7:0]         data_byte,
  input  logic signed [15:0] value_x,
  input  logic signed [15:0] value_y,
  input  logic signed [7:0]  scroll_step,
  input  logic [2:0]         button_bits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        pointer_x,
  output logic [11:0]        pointer_y,
  output logic signed [31:0] sum_dx,
  output logic signed [31:0] sum_dy,
  output logic signed [7:0]  sum_scroll,
  output logic [2:0]         buttons,
  output logic               changed,
  output logic [31:0]        resyncs,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data
);
  import ps2mt_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  in_full;
  logic  advance;
  logic  proc;
  logic  load;
  logic  is_poll;
  pkt_t  pkt;
  stat_t stat;
  logic [31:0] resync_total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_x <= 12'd1023;
      cfg.max_y <= 12'd767;
      cfg.wheel_mode <= 1'b0;
      cfg.timeout_ticks <= 10'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_X: cfg.max_x <= cfg_data;
        CFG_MAX_Y: cfg.max_y <= cfg_data;
        CFG_WHEEL_MODE: cfg.wheel_mode <= cfg_data[0];
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    is_poll = (item.operation == OP_POLL);
    advance = !is_poll || !out_valid || !out_stall;
    proc = in_full && advance;
    in_stall = in_full && !advance;
    load = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= load || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.operation <= operation;
      item.data_byte <= data_byte;
      item.value_x <= value_x;
      item.value_y <= value_y;
      item.scroll_step <= scroll_step;
      item.button_bits <= button_bits;
    end
  end

  ps2mt_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item         (item),
    .proc         (proc),
    .pkt          (pkt),
    .resync_total (resync_total)
  );

  ps2mt_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .proc (proc),
    .pkt  (pkt),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && is_poll) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_poll) begin
      pointer_x <= stat.pointer_x;
      pointer_y <= stat.pointer_y;
      sum_dx <= stat.sum_dx;
      sum_dy <= stat.sum_dy;
      sum_scroll <= stat.sum_scroll;
      buttons <= stat.buttons;
      changed <= stat.changed;
      resyncs <= resync_total;
    end
  end

endmodule
